// File: hdl/bmf_pkg.sv
// Shared types and constants for the 5x5 binary majority filter.
package bmf_pkg;

  localparam int CFG_W           = 11;
  localparam int PIX_W           = 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WIN_RADIUS      = 2;
  localparam int WIN_SIDE        = 2 * WIN_RADIUS + 1;
  localparam int WIN_BITS        = WIN_SIDE * WIN_SIDE;
  localparam int LINES           = WIN_SIDE - 1;
  localparam int CNT_W           = $clog2(WIN_BITS + 1);
  localparam int WHITE_THRESHOLD = 13;
  localparam int MIN_DIM         = 5;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
  localparam logic [PIX_W-1:0] PIX_WHITE    = PIX_W'(255);
  localparam logic [PIX_W-1:0] PIX_BLACK    = PIX_W'(0);

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;
  } out_word_t;

  // Position flags of one pixel, from the position tracker to the datapath.
  typedef struct packed {
    logic emit;
    logic inner;
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// File: hdl/bmf_position.sv
// Raster position tracker: column and row counters and per-pixel flags.
module bmf_position #(
  parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     frame_start,
  input  logic [bmf_pkg::CFG_W-1:0] image_width,
  input  logic [bmf_pkg::CFG_W-1:0] image_height,
  output logic [AW-1:0]            col,
  output bmf_pkg::pos_flags_t      flags
);
  import bmf_pkg::*;

  // Wide enough for the width register and for MAX_WIDTH itself.
  localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [AW-1:0]    column_count;
  logic [AW-1:0]    column_count_next;
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] row_count_next;
  logic [CFG_W-1:0] row;
  logic [WW-1:0]    width_ext;
  logic [WW-1:0]    width_eff;
  logic [CFG_W-1:0] height_eff;
  logic             line_done;
  logic             frame_done;

  assign col = frame_start ? '0 : column_count;
  assign row = frame_start ? '0 : row_count;

  always_comb begin
    width_ext = WW'(image_width);
    if (width_ext < WW'(MIN_DIM)) begin
      width_eff = WW'(MIN_DIM);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    height_eff = (image_height < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : image_height;
  end

  assign line_done  = WW'(col) >= (width_eff - WW'(1));
  assign frame_done = line_done && (row >= (height_eff - CFG_W'(1)));

  always_comb begin
    flags.emit      = (row >= CFG_W'(WIN_RADIUS)) && (WW'(col) >= WW'(WIN_RADIUS));
    flags.inner     = (row >= CFG_W'(2 * WIN_RADIUS)) && (WW'(col) >= WW'(2 * WIN_RADIUS));
    flags.row_end   = line_done;
    flags.frame_end = frame_done;
  end

  always_comb begin
    if (line_done) begin
      column_count_next = '0;
      row_count_next    = frame_done ? '0 : row + CFG_W'(1);
    end else begin
      column_count_next = col + AW'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: hdl/bmf_line_store.sv
// Four-line store: one word per column holding the four previous lines.
module bmf_line_store #(
  parameter int DEPTH = bmf_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bmf_pkg::LINES-1:0] wr_data,
  output logic [bmf_pkg::LINES-1:0] rd_data
);
  import bmf_pkg::*;

  logic [LINES-1:0] mem [DEPTH];
  logic [LINES-1:0] rd_q;
  logic [LINES-1:0] byp_q;
  logic             byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same column takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      byp_hit <= wr_en && (wr_addr == rd_addr);
      byp_q   <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_q : rd_q;

endmodule

// File: hdl/bmf_window.sv
// 5x5 window shift register and majority vote over its 25 bits.
module bmf_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [bmf_pkg::WIN_SIDE-1:0] column,
  output logic                         majority
);
  import bmf_pkg::*;

  logic [WIN_BITS-1:0] window_bits;
  logic [WIN_BITS-1:0] window_bits_next;
  logic [CNT_W-1:0]    ones;

  assign window_bits_next = {window_bits[WIN_BITS-WIN_SIDE-1:0], column};

  always_comb begin
    ones = '0;
    for (int i = 0; i < WIN_BITS; i++) begin
      ones = ones + CNT_W'(window_bits_next[i]);
    end
  end

  assign majority = ones >= CNT_W'(WHITE_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (shift) begin
      window_bits <= window_bits_next;
    end
  end

endmodule

// File: hdl/binary_majority_filter_5x5_unit.sv
// Top level of the 5x5 binary majority filter.
//
// The block takes a binary image in raster order, one word per pixel on the
// input channel (in_valid, in_ready, in_data), and returns one word per
// filtered center on the output channel (out_valid, out_ready, out_data).
// A nonzero pixel counts as white. The center two rows and columns behind
// the newest pixel is 255 when at least 13 of its 25 window pixels are
// white and 0 otherwise; centers in the two-pixel border give 0, and the
// last two rows and columns of a frame are never sent. Row and frame end
// flags mark the last word of a line and of a frame.
// Image size comes from a write port (cfg_we, cfg_index, cfg_data) and must be
// written only while the block is idle; the block itself does not enforce this.
// Width is clamped to 5..MAX_WIDTH and height to at least 5.
// An accepted word passes through stage one and then the output register;
// one word is taken every cycle unless the output stalls. The line store is
// read on accept, written when stage one retires, with a same-column bypass.
// If the receiver stalls, the word in the output register holds and the
// pipeline fills; in_ready then drops until out_ready returns.
// Reset clears the position, the window and both pipeline stages and loads
// 640 x 480; the line store is not cleared, which only border results see.
module binary_majority_filter_5x5_unit #(
  parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmf_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0] cfg_data
);
  import bmf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake. Stage one holds the accepted pixel while the line store read
  // completes; it retires straight away when it yields no output word.
  logic             in_fire;
  logic             s1_valid;
  logic             s1_white;
  logic [AW-1:0]    s1_col;
  pos_flags_t       s1_flags;
  logic             s1_advance;
  logic [AW-1:0]    col;
  pos_flags_t       flags;
  logic [LINES-1:0] lines_rd;
  logic [LINES-1:0] lines_wr;
  logic             majority;

  assign s1_advance = s1_valid && (!s1_flags.emit || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_fire    = in_valid && in_ready;

  bmf_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_fire),
    .frame_start  (in_data.frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (col),
    .flags        (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_white <= in_data.pixel != '0;
      s1_col   <= col;
      s1_flags <= flags;
    end
  end

  // The oldest line drops out and the new pixel becomes the newest line.
  assign lines_wr = {s1_white, lines_rd[LINES-1:1]};

  bmf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data (lines_wr),
    .rd_data (lines_rd)
  );

  bmf_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift    (s1_advance),
    .column   ({s1_white, lines_rd}),
    .majority (majority)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_flags.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_flags.emit) begin
      out_data.out_pixel <= (s1_flags.inner && majority) ? PIX_WHITE : PIX_BLACK;
      out_data.row_end   <= s1_flags.row_end;
      out_data.frame_end <= s1_flags.frame_end;
    end
  end

endmodule
